// ===== src/sgtr_pkg.sv =====
// Shared types, constants and helper functions of the scaled glyph text renderer.
package sgtr_pkg;

    localparam int CoordW     = 13;
    localparam int ScaleW     = 4;
    localparam int SizeW      = 6;
    localparam int GlyphBits  = 15;
    localparam int MaxScale   = 12;
    localparam int MaskW      = 3 * MaxScale;
    localparam int CodeW      = 8;
    localparam int CfgIndexW  = 2;

    localparam logic [CodeW-1:0]  NEWLINE_CODE    = 8'd10;
    localparam logic [CodeW-1:0]  FIRST_PRINTABLE = 8'd32;
    localparam logic [CodeW-1:0]  LAST_PRINTABLE  = 8'd126;
    localparam logic [GlyphBits-1:0] FULL_GLYPH   = 15'h7FFF;
    localparam logic [CoordW-1:0] CUR_MAX         = 13'd8191;

    localparam logic [CfgIndexW-1:0] CFG_FB_WIDTH    = 2'd0;
    localparam logic [CfgIndexW-1:0] CFG_FB_HEIGHT   = 2'd1;
    localparam logic [CfgIndexW-1:0] CFG_GLYPH_SCALE = 2'd2;

    typedef enum logic [1:0] {
        KIND_NEWLINE = 2'd0,
        KIND_ERROR   = 2'd1,
        KIND_DRAW    = 2'd2
    } kind_t;

    typedef struct packed {
        logic [CoordW-1:0] fb_width;
        logic [CoordW-1:0] fb_height;
        logic [ScaleW-1:0] glyph_scale;
    } cfg_t;

    typedef struct packed {
        kind_t                kind;
        logic [GlyphBits-1:0] bits;
    } entry_t;

    localparam logic [7:0] GLYPH_BYTES [190] = '{
        8'd0, 8'd0, 8'd146, 8'd32, 8'd45, 8'd0, 8'd85, 8'd85,
        8'd223, 8'd125, 8'd165, 8'd82, 8'd170, 8'd106, 8'd18, 8'd0,
        8'd94, 8'd102, 8'd51, 8'd61, 8'd213, 8'd85, 8'd210, 8'd37,
        8'd0, 8'd40, 8'd192, 8'd1, 8'd0, 8'd8, 8'd160, 8'd2,
        8'd106, 8'd43, 8'd147, 8'd116, 8'd231, 8'd115, 8'd231, 8'd121,
        8'd237, 8'd73, 8'd207, 8'd121, 8'd207, 8'd123, 8'd167, 8'd18,
        8'd239, 8'd123, 8'd239, 8'd121, 8'd16, 8'd4, 8'd16, 8'd20,
        8'd84, 8'd68, 8'd56, 8'd14, 8'd17, 8'd21, 8'd167, 8'd32,
        8'd239, 8'd115, 8'd234, 8'd91, 8'd235, 8'd58, 8'd79, 8'd114,
        8'd107, 8'd59, 8'd207, 8'd115, 8'd207, 8'd19, 8'd79, 8'd123,
        8'd237, 8'd91, 8'd151, 8'd116, 8'd39, 8'd123, 8'd93, 8'd86,
        8'd73, 8'd114, 8'd253, 8'd47, 8'd253, 8'd95, 8'd111, 8'd123,
        8'd239, 8'd19, 8'd111, 8'd79, 8'd239, 8'd90, 8'd143, 8'd120,
        8'd151, 8'd36, 8'd109, 8'd123, 8'd109, 8'd43, 8'd207, 8'd114,
        8'd173, 8'd90, 8'd173, 8'd36, 8'd167, 8'd114, 8'd79, 8'd114,
        8'd136, 8'd8, 8'd39, 8'd121, 8'd42, 8'd0, 8'd0, 8'd112,
        8'd17, 8'd0, 8'd152, 8'd43, 8'd201, 8'd123, 8'd120, 8'd114,
        8'd228, 8'd123, 8'd80, 8'd103, 8'd106, 8'd22, 8'd234, 8'd57,
        8'd201, 8'd91, 8'd130, 8'd36, 8'd130, 8'd52, 8'd233, 8'd90,
        8'd73, 8'd50, 8'd200, 8'd127, 8'd200, 8'd91, 8'd192, 8'd123,
        8'd120, 8'd31, 8'd120, 8'd79, 8'd80, 8'd19, 8'd240, 8'd56,
        8'd186, 8'd36, 8'd64, 8'd123, 8'd64, 8'd43, 8'd192, 8'd85,
        8'd64, 8'd85, 8'd64, 8'd21, 8'd56, 8'd117, 8'd212, 8'd68,
        8'd146, 8'd36, 8'd145, 8'd21, 8'd17, 8'd69
    };

    function automatic logic [GlyphBits-1:0] glyph_lookup(input logic [CodeW-1:0] code);
        logic [CodeW-1:0] k;
        logic [15:0]      word;
        k = 8'((code - FIRST_PRINTABLE) << 1);
        word = {GLYPH_BYTES[k + 8'd1], GLYPH_BYTES[k]};
        if (code < FIRST_PRINTABLE || code > LAST_PRINTABLE)
        begin
            return FULL_GLYPH;
        end
        return word[GlyphBits-1:0];
    endfunction

    function automatic logic [ScaleW-1:0] eff_scale(input logic [ScaleW-1:0] s);
        if (s == '0)
        begin
            return ScaleW'(1);
        end
        if (s > ScaleW'(MaxScale))
        begin
            return ScaleW'(MaxScale);
        end
        return s;
    endfunction

    function automatic logic [SizeW-1:0] glyph_w(input logic [ScaleW-1:0] s);
        return SizeW'({2'b0, s} << 1) + SizeW'(s);
    endfunction

    function automatic logic [SizeW-1:0] glyph_h(input logic [ScaleW-1:0] s);
        return SizeW'({2'b0, s} << 2) + SizeW'(s);
    endfunction

    function automatic logic [CoordW-1:0] sat_add(input logic [CoordW-1:0] a,
                                                  input logic [SizeW:0] b);
        logic [CoordW:0] sum;
        sum = {1'b0, a} + (CoordW+1)'(b);
        return sum[CoordW] ? CUR_MAX : sum[CoordW-1:0];
    endfunction

endpackage

// ===== src/scaled_glyph_text_renderer_core.sv =====
// Top level of the scaled glyph text renderer: configuration registers and wiring.
//
// Each character beat is looked up in a 3x5 font and drawn at the text cursor,
// magnified by glyph_scale. A drawn character gives 5*scale row beats, top row
// first, each with its row, start column and pixel mask; the last carries tlast.
// A character that cannot fit at the current scale gives one beat with the error
// flag set and leaves the cursor in place; a newline gives no beat. The row
// sequencer emits one row beat per cycle while the output register is free; a
// drawn character passes through the idle, vertical check and row states, an
// error through the idle and error states. A two-beat queue lets the input run
// ahead of the sequencer, and the output register holds each beat while it waits.
module scaled_glyph_text_renderer_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [7:0]                           s_axis_tdata,  // char_code
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [63:0]                          m_axis_tdata,  // row_y, start_x, pixel_mask
    output logic [0:0]                           m_axis_tuser,  // fit_error
    output logic                                 m_axis_tlast,
    input  logic                                 cfg_we,
    input  logic [sgtr_pkg::CfgIndexW-1:0]       cfg_index,
    input  logic [sgtr_pkg::CoordW-1:0]          cfg_data
);

    sgtr_pkg::cfg_t                  cfg_reg, cfg_next;
    logic                            push;
    sgtr_pkg::entry_t                push_entry;
    logic                            q_ready;
    logic                            q_valid;
    sgtr_pkg::entry_t                q_entry;
    logic                            pop;
    logic [sgtr_pkg::CoordW-1:0]     row_y;
    logic [sgtr_pkg::CoordW-1:0]     start_x;
    logic [sgtr_pkg::MaskW-1:0]      pixel_mask;
    logic                            fit_error;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                sgtr_pkg::CFG_FB_WIDTH:    cfg_next.fb_width = cfg_data;
                sgtr_pkg::CFG_FB_HEIGHT:   cfg_next.fb_height = cfg_data;
                sgtr_pkg::CFG_GLYPH_SCALE:
                    cfg_next.glyph_scale = cfg_data[sgtr_pkg::ScaleW-1:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fb_width <= 13'd640;
            cfg_reg.fb_height <= 13'd480;
            cfg_reg.glyph_scale <= 4'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    sgtr_front u_front
    (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .char_code     (s_axis_tdata),
        .cfg           (cfg_reg),
        .push          (push),
        .push_entry    (push_entry),
        .q_ready       (q_ready)
    );

    sgtr_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .q_ready    (q_ready),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_entry    (q_entry)
    );

    sgtr_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_valid       (q_valid),
        .q_entry       (q_entry),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .row_y         (row_y),
        .start_x       (start_x),
        .pixel_mask    (pixel_mask),
        .fit_error     (fit_error),
        .last_row      (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, pixel_mask, start_x, row_y};
    assign m_axis_tuser = fit_error;

endmodule

// ===== src/sgtr_front.sv =====
// Front end: looks up the glyph of each incoming character and classifies it.
module sgtr_front
(
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [sgtr_pkg::CodeW-1:0] char_code,
    input  sgtr_pkg::cfg_t             cfg,
    output logic                       push,
    output sgtr_pkg::entry_t           push_entry,
    input  logic                       q_ready
);

    logic [sgtr_pkg::ScaleW-1:0] scale;
    logic [sgtr_pkg::SizeW-1:0]  w;
    logic [sgtr_pkg::SizeW-1:0]  h;
    logic                        no_fit;

    assign scale = sgtr_pkg::eff_scale(cfg.glyph_scale);
    assign w = sgtr_pkg::glyph_w(scale);
    assign h = sgtr_pkg::glyph_h(scale);
    assign no_fit = (sgtr_pkg::CoordW'(w) > cfg.fb_width) ||
                    (sgtr_pkg::CoordW'(h) > cfg.fb_height);

    assign s_axis_tready = q_ready;
    assign push = s_axis_tvalid && q_ready;

    always_comb
    begin
        push_entry.bits = sgtr_pkg::glyph_lookup(char_code);
        if (char_code == sgtr_pkg::NEWLINE_CODE)
        begin
            push_entry.kind = sgtr_pkg::KIND_NEWLINE;
        end
        else if (no_fit)
        begin
            push_entry.kind = sgtr_pkg::KIND_ERROR;
        end
        else
        begin
            push_entry.kind = sgtr_pkg::KIND_DRAW;
        end
    end

endmodule

// ===== src/sgtr_queue.sv =====
// Two-entry queue that decouples the front end from the row sequencer.
module sgtr_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  sgtr_pkg::entry_t push_entry,
    output logic             q_ready,
    input  logic             pop,
    output logic             q_valid,
    output sgtr_pkg::entry_t q_entry
);

    sgtr_pkg::entry_t mem_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;

    assign q_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== src/sgtr_back.sv =====
// Back end: keeps the text cursor and emits one scaled glyph row per cycle while the output register is free.
module sgtr_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  sgtr_pkg::cfg_t              cfg,
    input  logic                        q_valid,
    input  sgtr_pkg::entry_t            q_entry,
    output logic                        pop,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [sgtr_pkg::CoordW-1:0] row_y,
    output logic [sgtr_pkg::CoordW-1:0] start_x,
    output logic [sgtr_pkg::MaskW-1:0]  pixel_mask,
    output logic                        fit_error,
    output logic                        last_row
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_VCHK = 4'b0010,
        ST_ROWS = 4'b0100,
        ST_ERR  = 4'b1000
    } state_t;

    localparam int CW = sgtr_pkg::CoordW;

    state_t                          state_reg, state_next;
    logic [CW-1:0]                   cursor_x_reg, cursor_x_next;
    logic [CW-1:0]                   cursor_y_reg, cursor_y_next;
    logic [sgtr_pkg::GlyphBits-1:0]  bits_reg, bits_next;
    logic [sgtr_pkg::SizeW-1:0]      row_reg, row_next;
    logic [sgtr_pkg::ScaleW-1:0]     sub_reg, sub_next;
    logic [2:0]                      grow_reg, grow_next;
    logic                            out_valid_reg, out_valid_next;
    logic [CW-1:0]                   row_y_reg, row_y_next;
    logic [CW-1:0]                   start_x_reg, start_x_next;
    logic [sgtr_pkg::MaskW-1:0]      mask_reg, mask_next;
    logic                            err_reg, err_next;
    logic                            last_reg, last_next;

    logic [sgtr_pkg::ScaleW-1:0]     scale;
    logic [sgtr_pkg::SizeW-1:0]      w;
    logic [sgtr_pkg::SizeW-1:0]      h;
    logic                            out_free;
    logic                            load;
    logic                            row_last;
    logic [2:0]                      row3;
    logic [sgtr_pkg::MaskW-1:0]      row_mask;
    logic [sgtr_pkg::ScaleW:0]       s2;
    logic [sgtr_pkg::ScaleW+1:0]     s3;

    assign scale = sgtr_pkg::eff_scale(cfg.glyph_scale);
    assign w = sgtr_pkg::glyph_w(scale);
    assign h = sgtr_pkg::glyph_h(scale);
    assign s2 = {1'b0, scale} << 1;
    assign s3 = 6'(s2) + 6'(scale);
    assign out_free = !out_valid_reg || m_axis_tready;
    assign row_last = (row_reg == h - 6'd1);
    assign pop = (state_reg == ST_IDLE) && q_valid;

    always_comb
    begin
        case (grow_reg)
            3'd0: row3 = bits_reg[2:0];
            3'd1: row3 = bits_reg[5:3];
            3'd2: row3 = bits_reg[8:6];
            3'd3: row3 = bits_reg[11:9];
            3'd4: row3 = bits_reg[14:12];
            default: row3 = 3'd0;
        endcase
    end

    always_comb
    begin
        for (int c = 0; c < sgtr_pkg::MaskW; c++)
        begin
            if (6'(c) < 6'(scale))
            begin
                row_mask[c] = row3[0];
            end
            else if (6'(c) < 6'(s2))
            begin
                row_mask[c] = row3[1];
            end
            else if (6'(c) < s3)
            begin
                row_mask[c] = row3[2];
            end
            else
            begin
                row_mask[c] = 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        bits_next = bits_reg;
        row_next = row_reg;
        sub_next = sub_reg;
        grow_next = grow_reg;
        load = 1'b0;
        row_y_next = row_y_reg;
        start_x_next = start_x_reg;
        mask_next = mask_reg;
        err_next = err_reg;
        last_next = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    bits_next = q_entry.bits;
                    row_next = '0;
                    sub_next = '0;
                    grow_next = '0;
                    case (q_entry.kind)
                        sgtr_pkg::KIND_NEWLINE:
                        begin
                            cursor_x_next = '0;
                            cursor_y_next = sgtr_pkg::sat_add(cursor_y_reg, {1'b0, h} + 7'd1);
                        end
                        sgtr_pkg::KIND_ERROR:
                        begin
                            state_next = ST_ERR;
                        end
                        default:
                        begin
                            if (({1'b0, cursor_x_reg} + (CW+1)'(w)) > {1'b0, cfg.fb_width})
                            begin
                                cursor_x_next = '0;
                                cursor_y_next = sgtr_pkg::sat_add(cursor_y_reg,
                                                                  {1'b0, h} + 7'd1);
                            end
                            state_next = ST_VCHK;
                        end
                    endcase
                end
            end
            ST_VCHK:
            begin
                if (({1'b0, cursor_y_reg} + (CW+1)'(h)) > {1'b0, cfg.fb_height})
                begin
                    cursor_y_next = '0;
                end
                state_next = ST_ROWS;
            end
            ST_ROWS:
            begin
                if (out_free)
                begin
                    load = 1'b1;
                    row_y_next = cursor_y_reg + CW'(row_reg);
                    start_x_next = cursor_x_reg;
                    mask_next = row_mask;
                    err_next = 1'b0;
                    last_next = row_last;
                    if (row_last)
                    begin
                        cursor_x_next = sgtr_pkg::sat_add(cursor_x_reg, {1'b0, w} + 7'd1);
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        row_next = row_reg + 6'd1;
                        if (sub_reg == scale - 4'd1)
                        begin
                            sub_next = '0;
                            grow_next = grow_reg + 3'd1;
                        end
                        else
                        begin
                            sub_next = sub_reg + 4'd1;
                        end
                    end
                end
            end
            ST_ERR:
            begin
                if (out_free)
                begin
                    load = 1'b1;
                    row_y_next = cursor_y_reg;
                    start_x_next = cursor_x_reg;
                    mask_next = '0;
                    err_next = 1'b1;
                    last_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = load || (out_valid_reg && !m_axis_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
        row_reg <= row_next;
        sub_reg <= sub_next;
        grow_reg <= grow_next;
        row_y_reg <= row_y_next;
        start_x_reg <= start_x_next;
        mask_reg <= mask_next;
        err_reg <= err_next;
        last_reg <= last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign row_y = row_y_reg;
    assign start_x = start_x_reg;
    assign pixel_mask = mask_reg;
    assign fit_error = err_reg;
    assign last_row = last_reg;

endmodule

// ===== src/sgtr_checker.sv =====
// Port-level checker for the scaled glyph text renderer and its bind.
module sgtr_checker
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [63:0]                        m_axis_tdata,
    input  logic [0:0]                         m_axis_tuser,
    input  logic                               m_axis_tlast
);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !s_axis_tready |=>
            s_axis_tvalid && $stable(s_axis_tdata))
        else $error("Input beat changed while stalled.");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
            $stable(m_axis_tlast))
        else $error("Output beat changed while stalled.");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
        else $error("Fit error beat is not marked last.");

    a_err_mask: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[61:26] == '0)
        else $error("Fit error beat carries pixels.");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[63:62] == 2'b00)
        else $error("Padding bits of the output beat are not zero.");

endmodule

bind scaled_glyph_text_renderer_core sgtr_checker u_sgtr_checker (.*);
